>>> rtl/bmp24_pkg.sv
// Shared constants and types for the 24-bit BMP to RGB565 pixel decoder.
package bmp24_pkg;

  localparam int MAX_WIDTH  = 480;
  localparam int MAX_HEIGHT = 320;

  // Display coordinate width; coordinates wrap modulo 2^COORD_W.
  localparam int COORD_W = 11;
  localparam int ORIGIN_W = 10;
  // Widths of the header-approved image width (WIDTH_W) and of the column counter (COL_W).
  localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Header byte positions.
  localparam logic [5:0] POS_SIG_B   = 6'd0;
  localparam logic [5:0] POS_SIG_M   = 6'd1;
  localparam logic [5:0] POS_FSIZE   = 6'd2;
  localparam logic [5:0] POS_OFFSET  = 6'd10;
  localparam logic [5:0] POS_INFO    = 6'd14;
  localparam logic [5:0] POS_INFO_HI = 6'd15;
  localparam logic [5:0] POS_WIDTH   = 6'd18;
  localparam logic [5:0] POS_HEIGHT  = 6'd22;
  localparam logic [5:0] POS_PLANES  = 6'd26;
  localparam logic [5:0] POS_PLN_HI  = 6'd27;
  localparam logic [5:0] POS_BPP     = 6'd28;
  localparam logic [5:0] POS_BPP_HI  = 6'd29;
  localparam logic [5:0] POS_COMP    = 6'd30;
  localparam logic [5:0] POS_LAST    = 6'd33;
  localparam logic [31:0] HDR_END    = 32'd34;

  localparam logic [7:0] SIG_B     = 8'h42;
  localparam logic [7:0] SIG_M     = 8'h4D;
  localparam logic [7:0] INFO_SIZE = 8'd40;
  localparam logic [7:0] PLANES    = 8'd1;
  localparam logic [7:0] BPP       = 8'd24;

  // Result kinds.
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  // Channel phase codes.
  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  // Header parser to pixel assembler.
  typedef struct packed {
    logic               restart;
    logic               pix_go;
    logic               reject;
    logic [WIDTH_W-1:0] width;
    logic [COORD_W-1:0] height;
  } hdr_info_t;

endpackage

>>> rtl/bmp24_stream_to_rgb565_pixels.sv
// Top level: 24-bit BMP byte stream to RGB565 pixel decoder.
// Usage:
//  - Byte channel (data_byte, file_start) with byte_valid / byte_ready. A transaction
//    moves one file byte; file_start on a byte restarts the parse at that byte.
//  - Result channel (kind, pixel_x, pixel_y, color) with result_valid / result_ready.
//    kind = pixel for each complete B, G, R triple; kind = reject once, on header
//    byte 33, when the header checks fail (coordinates and colour are then zero).
//  - Config port: wr_en, wr_index, wr_data writes origin_x or origin_y.
//    Write only while no transaction is in flight.
// Timing: each byte is handled in the cycle it is accepted; any result lands in the
//  output register and is shown on the next cycle. One byte per cycle is sustained
//  while result_ready is held high; the limit is the single output register, which is
//  refilled in the same cycle that the receiver takes its content.
// Stall: while a result waits and result_ready is low, byte_ready is low; bytes that
//  produce nothing are still blocked, so order is kept simply.
// Reset (rst, synchronous): clears the parse state, the origins and the output valid.
//  The first byte after reset is treated as byte 0 of a file even without file_start.
module bmp24_stream_to_rgb565_pixels (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  output logic                           byte_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           file_start,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           kind,
  output logic [bmp24_pkg::COORD_W-1:0]  pixel_x,
  output logic [bmp24_pkg::COORD_W-1:0]  pixel_y,
  output logic [15:0]                    color,
  input  logic                           wr_en,
  input  logic                           wr_index,
  input  logic [bmp24_pkg::ORIGIN_W-1:0] wr_data
);

  logic                           accept;
  bmp24_pkg::hdr_info_t           info;
  logic                           emit, produce;
  logic [bmp24_pkg::COORD_W-1:0]  px, py;
  logic [15:0]                    pcolor;
  logic [bmp24_pkg::ORIGIN_W-1:0] origin_x, origin_y;

  // Output register frees when the receiver takes it.
  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;
  assign produce    = emit || info.reject;

  bmp24_hdr u_hdr (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .file_start(file_start),
    .info      (info)
  );

  bmp24_pix u_pix (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .info      (info),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .emit      (emit),
    .pixel_x   (px),
    .pixel_y   (py),
    .color     (pcolor)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (wr_en) begin
      case (wr_index)
        bmp24_pkg::CFG_ORIGIN_X: origin_x <= wr_data;
        bmp24_pkg::CFG_ORIGIN_Y: origin_y <= wr_data;
        default: ;
      endcase
    end
  end

  // Result register: control under reset, payload loaded on a new result.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && produce) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      if (info.reject) begin
        kind    <= bmp24_pkg::KIND_REJECT;
        pixel_x <= '0;
        pixel_y <= '0;
        color   <= '0;
      end else begin
        kind    <= bmp24_pkg::KIND_PIXEL;
        pixel_x <= px;
        pixel_y <= py;
        color   <= pcolor;
      end
    end
  end

endmodule

>>> rtl/bmp24_hdr.sv
// Header capture and checking, byte index and pixel window for the BMP decoder.
module bmp24_hdr (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 file_start,
  output bmp24_pkg::hdr_info_t info
);

  logic [31:0] byte_index, file_size, pixel_offset, image_width, image_height;
  logic        header_bad;

  logic [31:0] idx, fs_e, off_e, w_e, h_e;
  logic        bad_e;
  logic [31:0] byte_index_next, file_size_next, pixel_offset_next;
  logic [31:0] image_width_next, image_height_next;
  logic        header_bad_next;
  logic [5:0]  idx6, sel;
  logic        in_hdr, last_hdr, dec_bad;
  logic [31:0] w_mag, h_mag;

  // A new file clears the parse before this byte is handled.
  assign idx   = file_start ? '0 : byte_index;
  assign fs_e  = file_start ? '0 : file_size;
  assign off_e = file_start ? '0 : pixel_offset;
  assign w_e   = file_start ? '0 : image_width;
  assign h_e   = file_start ? '0 : image_height;
  assign bad_e = file_start ? 1'b0 : header_bad;

  assign idx6     = idx[5:0];
  assign in_hdr   = (idx < bmp24_pkg::HDR_END);
  assign last_hdr = in_hdr && (idx6 == bmp24_pkg::POS_LAST);

  always_comb begin
    file_size_next    = fs_e;
    pixel_offset_next = off_e;
    image_width_next  = w_e;
    image_height_next = h_e;
    header_bad_next   = bad_e;
    sel               = '0;
    if (in_hdr) begin
      if (idx6 == bmp24_pkg::POS_SIG_B && data_byte != bmp24_pkg::SIG_B) header_bad_next = 1'b1;
      if (idx6 == bmp24_pkg::POS_SIG_M && data_byte != bmp24_pkg::SIG_M) header_bad_next = 1'b1;
      if (idx6 >= bmp24_pkg::POS_FSIZE && idx6 < bmp24_pkg::POS_FSIZE + 6'd4) begin
        sel = idx6 - bmp24_pkg::POS_FSIZE;
        file_size_next[{sel[1:0], 3'b000} +: 8] = data_byte;
      end
      if (idx6 >= bmp24_pkg::POS_OFFSET && idx6 < bmp24_pkg::POS_OFFSET + 6'd4) begin
        sel = idx6 - bmp24_pkg::POS_OFFSET;
        pixel_offset_next[{sel[1:0], 3'b000} +: 8] = data_byte;
      end
      if (idx6 == bmp24_pkg::POS_INFO && data_byte != bmp24_pkg::INFO_SIZE)
        header_bad_next = 1'b1;
      if (idx6 == bmp24_pkg::POS_INFO_HI && data_byte != 8'd0) header_bad_next = 1'b1;
      if (idx6 >= bmp24_pkg::POS_WIDTH && idx6 < bmp24_pkg::POS_WIDTH + 6'd4) begin
        sel = idx6 - bmp24_pkg::POS_WIDTH;
        image_width_next[{sel[1:0], 3'b000} +: 8] = data_byte;
      end
      if (idx6 >= bmp24_pkg::POS_HEIGHT && idx6 < bmp24_pkg::POS_HEIGHT + 6'd4) begin
        sel = idx6 - bmp24_pkg::POS_HEIGHT;
        image_height_next[{sel[1:0], 3'b000} +: 8] = data_byte;
      end
      if (idx6 == bmp24_pkg::POS_PLANES && data_byte != bmp24_pkg::PLANES)
        header_bad_next = 1'b1;
      if (idx6 == bmp24_pkg::POS_BPP && data_byte != bmp24_pkg::BPP) header_bad_next = 1'b1;
      if ((idx6 == bmp24_pkg::POS_PLN_HI || idx6 == bmp24_pkg::POS_BPP_HI ||
           idx6 >= bmp24_pkg::POS_COMP) && data_byte != 8'd0)
        header_bad_next = 1'b1;
    end
    // Final header byte: take magnitudes and decide.
    w_mag   = image_width_next[31] ? (~image_width_next + 32'd1) : image_width_next;
    h_mag   = image_height_next[31] ? (~image_height_next + 32'd1) : image_height_next;
    dec_bad = header_bad_next || (w_mag > 32'(bmp24_pkg::MAX_WIDTH)) ||
              (h_mag > 32'(bmp24_pkg::MAX_HEIGHT));
    if (last_hdr) begin
      image_width_next  = w_mag;
      image_height_next = h_mag;
      header_bad_next   = dec_bad;
    end
    byte_index_next = (idx == '1) ? idx : idx + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      file_size    <= '0;
      pixel_offset <= '0;
      image_width  <= '0;
      image_height <= '0;
      header_bad   <= 1'b0;
    end else if (accept) begin
      byte_index   <= byte_index_next;
      file_size    <= file_size_next;
      pixel_offset <= pixel_offset_next;
      image_width  <= image_width_next;
      image_height <= image_height_next;
      header_bad   <= header_bad_next;
    end
  end

  assign info.restart = file_start;
  assign info.reject  = last_hdr && dec_bad;
  assign info.pix_go  = !in_hdr && !bad_e && (idx >= off_e) && (idx < fs_e);
  // Only used inside the pixel window, where the header passed its size checks.
  assign info.width   = image_width[bmp24_pkg::WIDTH_W-1:0];
  assign info.height  = image_height[bmp24_pkg::COORD_W-1:0];

endmodule

>>> rtl/bmp24_pix.sv
// Pixel assembly: B, G, R grouping, row padding and display coordinates.
module bmp24_pix (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [7:0]                      data_byte,
  input  bmp24_pkg::hdr_info_t            info,
  input  logic [bmp24_pkg::ORIGIN_W-1:0]  origin_x,
  input  logic [bmp24_pkg::ORIGIN_W-1:0]  origin_y,
  output logic                            emit,
  output logic [bmp24_pkg::COORD_W-1:0]   pixel_x,
  output logic [bmp24_pkg::COORD_W-1:0]   pixel_y,
  output logic [15:0]                     color
);

  logic [1:0]                    channel_phase, channel_phase_next, ph_e;
  logic [7:0]                    blue_hold, blue_hold_next, green_hold, green_hold_next;
  logic [bmp24_pkg::COL_W-1:0]   column_count, column_count_next, col_e;
  logic [bmp24_pkg::COORD_W-1:0] row_count, row_count_next, row_e;
  logic [1:0]                    pad_remaining, pad_remaining_next, pad_e;
  logic                          row_end;

  assign ph_e  = info.restart ? '0 : channel_phase;
  assign col_e = info.restart ? '0 : column_count;
  assign row_e = info.restart ? '0 : row_count;
  assign pad_e = info.restart ? '0 : pad_remaining;

  assign row_end = (32'(col_e) + 32'd1) >= 32'(info.width);

  always_comb begin
    channel_phase_next = ph_e;
    blue_hold_next     = info.restart ? '0 : blue_hold;
    green_hold_next    = info.restart ? '0 : green_hold;
    column_count_next  = col_e;
    row_count_next     = row_e;
    pad_remaining_next = pad_e;
    emit               = 1'b0;
    if (info.pix_go) begin
      if (pad_e != 2'd0) begin
        pad_remaining_next = pad_e - 2'd1;
      end else begin
        case (ph_e)
          bmp24_pkg::PH_GREEN: begin
            green_hold_next    = data_byte;
            channel_phase_next = bmp24_pkg::PH_RED;
          end
          bmp24_pkg::PH_RED: begin
            emit               = 1'b1;
            channel_phase_next = bmp24_pkg::PH_BLUE;
            if (row_end) begin
              column_count_next  = '0;
              row_count_next     = row_e + bmp24_pkg::COORD_W'(1);
              pad_remaining_next = info.width[1:0];
            end else begin
              column_count_next = col_e + bmp24_pkg::COL_W'(1);
            end
          end
          default: begin
            // blue, and the unused phase code
            blue_hold_next     = data_byte;
            channel_phase_next = bmp24_pkg::PH_GREEN;
          end
        endcase
      end
    end
  end

  assign color   = {data_byte[7:3], green_hold[7:2], blue_hold[7:3]};
  assign pixel_x = bmp24_pkg::COORD_W'(origin_x) + bmp24_pkg::COORD_W'(col_e);
  assign pixel_y = bmp24_pkg::COORD_W'(origin_y) + info.height - row_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_phase <= bmp24_pkg::PH_BLUE;
      blue_hold     <= '0;
      green_hold    <= '0;
      column_count  <= '0;
      row_count     <= '0;
      pad_remaining <= '0;
    end else if (accept) begin
      channel_phase <= channel_phase_next;
      blue_hold     <= blue_hold_next;
      green_hold    <= green_hold_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      pad_remaining <= pad_remaining_next;
    end
  end

endmodule
